// ===== hdl/acdu_pkg.sv =====
`default_nettype none

package acdu_pkg;

	localparam int COLUMNS  = 4;
	localparam int COUNT_W  = 3;
	localparam int DEP_BITS = 16;
	localparam int SLOT_W   = $clog2(COLUMNS);

	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [DEP_BITS-1:0] dep_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	typedef struct packed {
		count_t in_count_0;
		count_t in_count_1;
		count_t in_count_2;
		count_t in_count_3;
		count_t out_count_0;
		count_t out_count_1;
		count_t out_count_2;
		count_t out_count_3;
		dep_t   dep_in_0;
		dep_t   dep_in_1;
		dep_t   dep_in_2;
		dep_t   dep_in_3;
	} req_t;

	typedef struct packed {
		dep_t dep_out_0;
		dep_t dep_out_1;
		dep_t dep_out_2;
		dep_t dep_out_3;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/acdu_if.sv =====
`default_nettype none

interface acdu_req_if
	import acdu_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface acdu_rsp_if
	import acdu_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/acdu_alloc.sv =====
`default_nettype none

module acdu_alloc
	import acdu_pkg::*;
(
	input  count_t src     [COLUMNS],
	input  count_t room    [COLUMNS],
	input  dep_t   dep     [COLUMNS],
	output dep_t   dep_out [COLUMNS]
);

	slot_t  rank   [COLUMNS];
	count_t sorted [COLUMNS];
	count_t rem    [COLUMNS];
	dep_t   acc    [COLUMNS];
	count_t left;

	// Sort position of each output column: smaller room first, equal room
	// puts the higher column index first.
	always_comb begin
		for (int c = 0; c < COLUMNS; c++) begin
			rank[c] = '0;
			for (int j = 0; j < COLUMNS; j++) begin
				if (room[j] < room[c] || (j > c && room[j] == room[c])) begin
					rank[c] = rank[c] + slot_t'(1);
				end
			end
		end
	end

	always_comb begin
		for (int s = 0; s < COLUMNS; s++) begin
			sorted[s] = '0;
			for (int c = 0; c < COLUMNS; c++) begin
				if (rank[c] == slot_t'(s)) begin
					sorted[s] = room[c];
				end
			end
		end
	end

	// Greedy hand-out: each input column gives one byte to each slot with room,
	// lowest sorted slot first, until its bytes run out.
	always_comb begin
		left = '0;
		for (int s = 0; s < COLUMNS; s++) begin
			rem[s] = sorted[s];
			acc[s] = '0;
		end
		for (int i = 0; i < COLUMNS; i++) begin
			left = src[i];
			for (int s = 0; s < COLUMNS; s++) begin
				if (left != '0 && rem[s] != '0) begin
					acc[s] = acc[s] | dep[i];
					rem[s] = rem[s] - count_t'(1);
					left   = left - count_t'(1);
				end
			end
		end
	end

	// Back to original column order.
	always_comb begin
		for (int c = 0; c < COLUMNS; c++) begin
			dep_out[c] = acc[rank[c]];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aes_column_dependency_update.sv =====
`default_nettype none

// Column dependency update: each request carries four input-column byte
// counts, four output-column byte counts and four input dependency masks, and
// produces one response with the four new output-column masks. The block is a
// two-register pipeline (request register, response register) with the sort,
// the greedy byte hand-out and the unsort in one combinational pass between
// them, so it takes one request per cycle while the response side does not
// stall, and each request's result goes from the request register through the
// response register to the port. Back-pressure on the response side stalls
// both registers; no state carries from one request to the next.
module aes_column_dependency_update_core
	import acdu_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	acdu_req_if.sink   req,
	acdu_rsp_if.source rsp
);

	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	rsp_t   rsp_s2;
	logic   adv_s2;
	logic   adv_s1;

	count_t src     [COLUMNS];
	count_t room    [COLUMNS];
	dep_t   dep     [COLUMNS];
	dep_t   dep_new [COLUMNS];

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= req.data;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2.dep_out_0 <= dep_new[0];
			rsp_s2.dep_out_1 <= dep_new[1];
			rsp_s2.dep_out_2 <= dep_new[2];
			rsp_s2.dep_out_3 <= dep_new[3];
		end
	end

	assign src[0]  = req_s1.in_count_0;
	assign src[1]  = req_s1.in_count_1;
	assign src[2]  = req_s1.in_count_2;
	assign src[3]  = req_s1.in_count_3;
	assign room[0] = req_s1.out_count_0;
	assign room[1] = req_s1.out_count_1;
	assign room[2] = req_s1.out_count_2;
	assign room[3] = req_s1.out_count_3;
	assign dep[0]  = req_s1.dep_in_0;
	assign dep[1]  = req_s1.dep_in_1;
	assign dep[2]  = req_s1.dep_in_2;
	assign dep[3]  = req_s1.dep_in_3;

	acdu_alloc u_alloc (
		.src     (src),
		.room    (room),
		.dep     (dep),
		.dep_out (dep_new)
	);

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

endmodule

`default_nettype wire
